[sv/jtag_scan_sequencer_assert.svh]
// assertion macros used by the jtag scan sequencer rtl
`ifndef JTAG_SCAN_SEQUENCER_ASSERT_SVH
`define JTAG_SCAN_SEQUENCER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define JSS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define JSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/jss_pkg.sv]
// types and constants of the jtag scan sequencer
`default_nettype none

package jss_pkg;

  localparam int unsigned HDR_W = 8;
  localparam int unsigned TDI_W = 16;
  localparam int unsigned TDO_W = 16;
  localparam int unsigned LEN_W = 5;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned BITS_W = 6;

  localparam logic [HDR_W-1:0] TYPE_MASK   = 8'hE0;
  localparam logic [HDR_W-1:0] TYPE_DR_BIT = 8'h80;
  localparam logic [HDR_W-1:0] TYPE_DRRTI  = 8'hC0;
  localparam logic [HDR_W-1:0] TYPE_DROUT  = 8'hA0;
  localparam logic [HDR_W-1:0] LEN_MASK    = 8'h1F;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SEL_DR  = 3'd1,
    PH_SEL_IR  = 3'd2,
    PH_CAPTURE = 3'd3,
    PH_ENTER   = 3'd4,
    PH_SHIFT   = 3'd5,
    PH_UPDATE  = 3'd6,
    PH_RTI     = 3'd7
  } jss_phase_e;

  typedef struct packed {
    logic             cmd;
    logic [HDR_W-1:0] header;
    logic [TDI_W-1:0] tdi_value;
    logic             tdo_sample;
  } jss_item_t;

  typedef struct packed {
    logic             tms_level;
    logic             tdi_level;
    logic             last;
    logic [TDO_W-1:0] tdo_word;
  } jss_result_t;

  typedef struct packed {
    logic        valid;
    jss_result_t result;
  } jss_step_t;

endpackage

`default_nettype wire

[sv/jss_in_stage.sv]
// input register of the jtag scan sequencer
`default_nettype none

module jss_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_valid_i,
  output logic                   s_ready_o,
  input  wire jss_pkg::jss_item_t s_item_i,
  input  wire logic              take_i,
  output logic                   item_valid_o,
  output jss_pkg::jss_item_t     item_o
);

  logic               valid_q, valid_d;
  jss_pkg::jss_item_t item_q;

  // slot frees when its transaction is taken downstream
  assign s_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (s_ready_o) begin
      valid_d = s_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      item_q <= s_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

[sv/jss_scan_fsm.sv]
// tap scan state machine: phase, shift and capture state, per-pulse result
`default_nettype none
`include "jtag_scan_sequencer_assert.svh"

module jss_scan_fsm #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fire_i,
  input  wire jss_pkg::jss_item_t item_i,
  output jss_pkg::jss_step_t      step_o
);

  localparam int unsigned IdxW = $clog2(DATA_WIDTH);

  jss_pkg::jss_phase_e                phase_q, phase_d;
  logic [jss_pkg::KIND_W-1:0]         kind_q, kind_d;
  logic [jss_pkg::BITS_W-1:0]         bits_left_q, bits_left_d;
  logic [jss_pkg::TDI_W-1:0]          tdi_shift_q, tdi_shift_d;
  logic [DATA_WIDTH-1:0]              tdo_collect_q, tdo_collect_d;
  logic [jss_pkg::LEN_W-1:0]          capture_pos_q, capture_pos_d;

  logic [jss_pkg::HDR_W-1:0] kind_bits;
  logic                      is_load;
  logic                      is_tick;
  logic                      shift_done;

  assign kind_bits  = {kind_q, {jss_pkg::LEN_W{1'b0}}};
  assign is_load    = fire_i && (item_i.cmd == jss_pkg::CMD_LOAD);
  assign is_tick    = fire_i && (item_i.cmd == jss_pkg::CMD_TICK);
  assign shift_done = (bits_left_q <= jss_pkg::BITS_W'(1));

  // next state and datapath
  always_comb begin
    phase_d       = phase_q;
    kind_d        = kind_q;
    bits_left_d   = bits_left_q;
    tdi_shift_d   = tdi_shift_q;
    tdo_collect_d = tdo_collect_q;
    capture_pos_d = capture_pos_q;
    if (is_load) begin
      if ((item_i.header != '0) && (phase_q == jss_pkg::PH_IDLE)) begin
        kind_d        = item_i.header[jss_pkg::HDR_W-1 -: jss_pkg::KIND_W];
        bits_left_d   = {1'b0, item_i.header[jss_pkg::LEN_W-1:0]} + jss_pkg::BITS_W'(1);
        tdi_shift_d   = item_i.tdi_value;
        tdo_collect_d = '0;
        capture_pos_d = '0;
        phase_d       = jss_pkg::PH_SEL_DR;
      end
    end else if (is_tick) begin
      case (phase_q)
        jss_pkg::PH_SEL_DR: begin
          phase_d = ((kind_bits & jss_pkg::TYPE_DR_BIT) != '0) ? jss_pkg::PH_CAPTURE
                                                               : jss_pkg::PH_SEL_IR;
        end
        jss_pkg::PH_SEL_IR:  phase_d = jss_pkg::PH_CAPTURE;
        jss_pkg::PH_CAPTURE: phase_d = jss_pkg::PH_ENTER;
        jss_pkg::PH_ENTER:   phase_d = jss_pkg::PH_SHIFT;
        jss_pkg::PH_SHIFT: begin
          tdi_shift_d = tdi_shift_q >> 1;
          if (kind_bits == jss_pkg::TYPE_DROUT) begin
            // positions past the register width are dropped
            if ({1'b0, capture_pos_q} < (jss_pkg::LEN_W + 1)'(DATA_WIDTH)) begin
              tdo_collect_d[capture_pos_q[IdxW-1:0]] =
                tdo_collect_q[capture_pos_q[IdxW-1:0]] | item_i.tdo_sample;
            end
            capture_pos_d = capture_pos_q + jss_pkg::LEN_W'(1);
          end
          if (shift_done) begin
            bits_left_d = '0;
            phase_d     = jss_pkg::PH_UPDATE;
          end else begin
            bits_left_d = bits_left_q - jss_pkg::BITS_W'(1);
          end
        end
        jss_pkg::PH_UPDATE: begin
          phase_d = (kind_bits == jss_pkg::TYPE_DRRTI) ? jss_pkg::PH_RTI : jss_pkg::PH_IDLE;
        end
        jss_pkg::PH_RTI:  phase_d = jss_pkg::PH_IDLE;
        default:          phase_d = phase_q;
      endcase
    end
  end

  // pulse levels for the current phase
  always_comb begin
    step_o = '0;
    if (is_tick) begin
      case (phase_q)
        jss_pkg::PH_SEL_DR: begin
          step_o.valid            = 1'b1;
          step_o.result.tms_level = 1'b1;
        end
        jss_pkg::PH_SEL_IR: begin
          step_o.valid            = 1'b1;
          step_o.result.tms_level = 1'b1;
        end
        jss_pkg::PH_CAPTURE: step_o.valid = 1'b1;
        jss_pkg::PH_ENTER:   step_o.valid = 1'b1;
        jss_pkg::PH_SHIFT: begin
          step_o.valid            = 1'b1;
          step_o.result.tdi_level = tdi_shift_q[0];
          step_o.result.tms_level = shift_done;
        end
        jss_pkg::PH_UPDATE: begin
          step_o.valid            = 1'b1;
          step_o.result.tms_level = 1'b1;
          step_o.result.last      = (kind_bits != jss_pkg::TYPE_DRRTI);
        end
        jss_pkg::PH_RTI: begin
          step_o.valid       = 1'b1;
          step_o.result.last = 1'b1;
        end
        default: step_o.valid = 1'b0;
      endcase
      if (step_o.result.last) begin
        step_o.result.tdo_word = tdo_collect_q[jss_pkg::TDO_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= jss_pkg::PH_IDLE;
      kind_q        <= '0;
      bits_left_q   <= '0;
      tdi_shift_q   <= '0;
      tdo_collect_q <= '0;
      capture_pos_q <= '0;
    end else begin
      phase_q       <= phase_d;
      kind_q        <= kind_d;
      bits_left_q   <= bits_left_d;
      tdi_shift_q   <= tdi_shift_d;
      tdo_collect_q <= tdo_collect_d;
      capture_pos_q <= capture_pos_d;
    end
  end

  `JSS_ASSERT_NEXT(a_last_ends_scan, step_o.valid && step_o.result.last,
                   phase_q == jss_pkg::PH_IDLE, "scan did not return to idle after last pulse")
  `JSS_ASSERT_IMPL(a_tdo_only_on_last, step_o.valid && !step_o.result.last,
                   step_o.result.tdo_word == '0, "tdo word nonzero outside last pulse")
  `JSS_ASSERT_NEXT(a_load_starts_scan,
                   is_load && (item_i.header != '0) && (phase_q == jss_pkg::PH_IDLE),
                   phase_q == jss_pkg::PH_SEL_DR, "accepted load did not start a scan")

endmodule

`default_nettype wire

[sv/jss_out_stage.sv]
// result register of the jtag scan sequencer
`default_nettype none

module jss_out_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire jss_pkg::jss_step_t   step_i,
  output logic                      free_o,
  output logic                      m_valid_o,
  input  wire logic                 m_ready_i,
  output jss_pkg::jss_result_t      m_result_o
);

  logic                 valid_q, valid_d;
  jss_pkg::jss_result_t result_q;

  assign free_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = step_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && step_i.valid) begin
      result_q <= step_i.result;
    end
  end

  assign m_valid_o  = valid_q;
  assign m_result_o = result_q;

endmodule

`default_nettype wire

[sv/jtag_scan_sequencer.sv]
// top level of the jtag scan sequencer
`default_nettype none

// jtag scan sequencer: steps a jtag tap through one scan, one tck pulse per tick
// transaction. a load transaction (tuser 0) takes a scan header and up to 16 tdi
// bits; it is dropped when the header is zero or a scan is still running. each tick
// transaction (tuser 1) during a scan yields one result transaction with the tms and
// tdi levels of the pulse; ticks while idle and loads yield none. pulse order is
// select-dr, select-ir (skipped when header bit 7 is set), capture, shift entry, the
// shifted bits lsb first with tms high on the last one, update, and run-test/idle for
// the drrti type only. only the drout type records tdo; tdo_word carries it on the
// last pulse (tlast high) and is zero otherwise. the block takes one transaction
// every clock unless the result side stalls; an input register holds it, then the
// phase state machine updates state and fills the result register in the same cycle.
// a stalled result register holds the input register, so a full stall costs no data.

module jtag_scan_sequencer #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [7:0] header, [23:8] tdi_value, [24] tdo_sample, [31:25] zero
  input  wire logic [31:0] s_axis_tdata_i,
  // [0] cmd
  input  wire logic        s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [0] tms_level, [1] tdi_level, [17:2] tdo_word, [23:18] zero
  output logic [23:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o
);

  jss_pkg::jss_item_t   s_item;
  jss_pkg::jss_item_t   item;
  logic                 item_valid;
  logic                 out_free;
  logic                 take;
  jss_pkg::jss_step_t   step;
  jss_pkg::jss_result_t m_result;

  // unpack the slave-side transaction
  assign s_item.cmd        = s_axis_tuser_i;
  assign s_item.header     = s_axis_tdata_i[7:0];
  assign s_item.tdi_value  = s_axis_tdata_i[23:8];
  assign s_item.tdo_sample = s_axis_tdata_i[24];

  // the held item is worked once the result register can take its outcome
  assign take = item_valid && out_free;

  jss_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_item_i     (s_item),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  jss_scan_fsm #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_scan_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (take),
    .item_i (item),
    .step_o (step)
  );

  jss_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .free_o     (out_free),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_result_o (m_result)
  );

  // pack the master-side transaction
  assign m_axis_tdata_o = {6'b0, m_result.tdo_word, m_result.tdi_level, m_result.tms_level};
  assign m_axis_tlast_o = m_result.last;

endmodule

`default_nettype wire

[tb/testbench.sv]
// self-checking regression bench for the jtag scan sequencer
`timescale 1ns / 1ps

module testbench;

  // ir scans are any type with bit 7 clear; the package only names the dr-side codes
  localparam logic [jss_pkg::HDR_W-1:0] TYPE_IR = 8'h40;
  localparam int unsigned DIRECTED_ROWS = 25;
  localparam int unsigned RANDOM_ITEMS = 480;
  localparam int unsigned QUIET_LIMIT = 300;
  localparam int unsigned MAX_PRINTED = 100;

  // one row of the directed plan; typed rows carry their pulse, the rest use the predictor
  typedef struct packed {
    logic                      cmd;
    logic [jss_pkg::HDR_W-1:0] hdr;
    logic [jss_pkg::TDI_W-1:0] tdi;
    logic                      tdo;
    logic                      typed;
    logic                      has_pulse;
    jss_pkg::jss_result_t      want;
  } plan_row_t;

  localparam jss_pkg::jss_result_t NO_PULSE = '0;

  localparam plan_row_t PLAN [0:DIRECTED_ROWS-1] = '{
    // tick while idle, zero header, tick still idle
    '{jss_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b0, NO_PULSE},
    '{jss_pkg::CMD_LOAD, 8'h00, 16'hFFFF, 1'b1, 1'b1, 1'b0, NO_PULSE},
    '{jss_pkg::CMD_TICK, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, NO_PULSE},
    // one-bit ir scan, with a load while busy after select-dr
    '{jss_pkg::CMD_LOAD, TYPE_IR, 16'hFFFF, 1'b0, 1'b1, 1'b0, NO_PULSE},
    '{jss_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b1, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 16'h0000}},
    '{jss_pkg::CMD_LOAD, 8'hFF, 16'h0000, 1'b1, 1'b1, 1'b0, NO_PULSE},
    '{jss_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 16'h0000}},
    '{jss_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 16'h0000}},
    '{jss_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 16'h0000}},
    '{jss_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0, 16'h0000}},
    '{jss_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b1, 16'h0000}},
    // two-bit drout scan capturing tdo
    '{jss_pkg::CMD_LOAD, jss_pkg::TYPE_DROUT | 8'h01, 16'h0002, 1'b0, 1'b1, 1'b0, NO_PULSE},
    '{jss_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, NO_PULSE},
    '{jss_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b0, NO_PULSE},
    '{jss_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, NO_PULSE},
    '{jss_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b0, NO_PULSE},
    '{jss_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b0, NO_PULSE},
    '{jss_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, NO_PULSE},
    // one-bit drrti scan ending in run-test/idle
    '{jss_pkg::CMD_LOAD, jss_pkg::TYPE_DRRTI, 16'hFFFF, 1'b0, 1'b1, 1'b0, NO_PULSE},
    '{jss_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, NO_PULSE},
    '{jss_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b0, NO_PULSE},
    '{jss_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, NO_PULSE},
    '{jss_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b0, NO_PULSE},
    '{jss_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, NO_PULSE},
    '{jss_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b0, NO_PULSE}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_valid = 1'b0;
  logic [31:0]       s_data = '0;
  logic              s_user = 1'b0;
  logic              m_ready = 1'b0;
  wire logic         s_axis_tready_o;
  wire logic         m_axis_tvalid_o;
  wire logic [23:0]  m_axis_tdata_o;
  wire logic         m_axis_tlast_o;

  // mirror of the tap walk
  jss_pkg::jss_phase_e        tap_phase = jss_pkg::PH_IDLE;
  logic [jss_pkg::KIND_W-1:0] tap_kind = '0;
  logic [jss_pkg::BITS_W-1:0] tap_bits_left = '0;
  logic [jss_pkg::TDI_W-1:0]  tap_tdi = '0;
  logic [jss_pkg::TDO_W-1:0]  tap_tdo = '0;
  logic [jss_pkg::LEN_W-1:0]  tap_pos = '0;

  jss_pkg::jss_result_t pulse_q [$];
  int unsigned          mismatches = 0;
  int unsigned          useful_items = 0;
  bit                   gapless = 1'b0;

  always #5 clk_i = ~clk_i;

  jtag_scan_sequencer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch on %s: got %0h, want %0h at %0t ns", what, got, want, $time);
  endtask

  // advance the tap mirror by one transaction; pulsed says a result transaction follows
  task automatic tap_step(input logic cmd, input logic [jss_pkg::HDR_W-1:0] hdr,
                          input logic [jss_pkg::TDI_W-1:0] tdi, input logic tdo,
                          output bit pulsed, output bit useful,
                          output jss_pkg::jss_result_t res);
    logic [jss_pkg::HDR_W-1:0] kind_code;
    kind_code = {tap_kind, 5'b0};
    res = '0;
    pulsed = 1'b0;
    useful = 1'b0;
    if (cmd == jss_pkg::CMD_LOAD) begin
      // zero header and load while busy are both dropped
      if (hdr != '0 && tap_phase == jss_pkg::PH_IDLE) begin
        tap_kind = hdr[7:5];
        tap_bits_left = jss_pkg::BITS_W'(hdr & jss_pkg::LEN_MASK) + 1'b1;
        tap_tdi = tdi;
        tap_tdo = '0;
        tap_pos = '0;
        tap_phase = jss_pkg::PH_SEL_DR;
        useful = 1'b1;
      end
      return;
    end
    pulsed = (tap_phase != jss_pkg::PH_IDLE);
    useful = pulsed;
    case (tap_phase)
      jss_pkg::PH_SEL_DR: begin
        res.tms_level = 1'b1;
        // dr-side types skip select-ir
        tap_phase = ((kind_code & jss_pkg::TYPE_DR_BIT) != '0) ? jss_pkg::PH_CAPTURE
                                                                : jss_pkg::PH_SEL_IR;
      end
      jss_pkg::PH_SEL_IR: begin
        res.tms_level = 1'b1;
        tap_phase = jss_pkg::PH_CAPTURE;
      end
      jss_pkg::PH_CAPTURE: tap_phase = jss_pkg::PH_ENTER;
      jss_pkg::PH_ENTER:   tap_phase = jss_pkg::PH_SHIFT;
      jss_pkg::PH_SHIFT: begin
        res.tdi_level = tap_tdi[0];
        tap_tdi = tap_tdi >> 1;
        if (kind_code == jss_pkg::TYPE_DROUT) begin
          // positions past the tdo word are dropped
          if (tap_pos < jss_pkg::TDO_W && tdo) tap_tdo[tap_pos[3:0]] = 1'b1;
          tap_pos = tap_pos + 1'b1;
        end
        if (tap_bits_left <= 1) begin
          res.tms_level = 1'b1;
          tap_bits_left = '0;
          tap_phase = jss_pkg::PH_UPDATE;
        end else begin
          tap_bits_left = tap_bits_left - 1'b1;
        end
      end
      jss_pkg::PH_UPDATE: begin
        res.tms_level = 1'b1;
        if (kind_code == jss_pkg::TYPE_DRRTI) begin
          tap_phase = jss_pkg::PH_RTI;
        end else begin
          res.last = 1'b1;
          tap_phase = jss_pkg::PH_IDLE;
        end
      end
      jss_pkg::PH_RTI: begin
        res.last = 1'b1;
        tap_phase = jss_pkg::PH_IDLE;
      end
      default: ;
    endcase
    if (res.last) res.tdo_word = tap_tdo;
  endtask

  // present one transaction after a random gap (none when gapless) and book its pulse once it is taken
  task automatic send_item(input logic cmd, input logic [jss_pkg::HDR_W-1:0] hdr,
                           input logic [jss_pkg::TDI_W-1:0] tdi, input logic tdo,
                           input bit typed, input bit typed_pulse,
                           input jss_pkg::jss_result_t want);
    int unsigned gap;
    bit pulsed;
    bit useful;
    jss_pkg::jss_result_t res;
    gap = gapless ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {7'b0, tdo, tdi, hdr};
    s_user <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    tap_step(cmd, hdr, tdi, tdo, pulsed, useful, res);
    if (useful) useful_items++;
    if (typed) begin
      if (typed_pulse) pulse_q.push_back(want);
    end else if (pulsed) begin
      pulse_q.push_back(res);
    end
  endtask

  task automatic send_random(input logic cmd, input logic [jss_pkg::HDR_W-1:0] hdr);
    logic [jss_pkg::TDI_W-1:0] tdi;
    case ($urandom_range(0, 7))
      0:       tdi = '0;
      1:       tdi = '1;
      default: tdi = jss_pkg::TDI_W'($urandom_range(0, 65535));
    endcase
    send_item(cmd, hdr, tdi, 1'(($urandom_range(0, 1))), 1'b0, 1'b0, NO_PULSE);
  endtask

  function automatic logic [jss_pkg::HDR_W-1:0] pick_header();
    logic [jss_pkg::LEN_W-1:0] len;
    case ($urandom_range(0, 9))
      0:       len = '1;
      1, 2:    len = jss_pkg::LEN_W'($urandom_range(0, 31));
      default: len = jss_pkg::LEN_W'($urandom_range(0, 5));
    endcase
    return {3'($urandom_range(0, 7)), len};
  endfunction

  // stimulus: directed plan, then random scans with noise mixed in
  initial begin
    bit paused;
    paused = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_item(PLAN[i].cmd, PLAN[i].hdr, PLAN[i].tdi, PLAN[i].tdo,
                PLAN[i].typed, PLAN[i].has_pulse, PLAN[i].want);
    end
    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) begin
      gapless = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // noise between scans: idle tick or zero-header load
        send_random(1'($urandom_range(0, 1)), '0);
      end else begin
        send_random(jss_pkg::CMD_LOAD, pick_header());
        while (tap_phase != jss_pkg::PH_IDLE) begin
          if ($urandom_range(0, 11) == 0) send_random(jss_pkg::CMD_LOAD, pick_header());
          else send_random(jss_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
        end
      end
      // halfway through, hold off until the block has drained
      if (!paused && useful_items >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        s_valid <= 1'b0;
        @(posedge clk_i);
        while (pulse_q.size() != 0) @(posedge clk_i);
      end
    end
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pulse_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("jtag_scan_sequencer regression: pass");
    end else begin
      $display("jtag_scan_sequencer regression: fail");
    end
    $finish;
  end

  // result side back-pressure, with occasional stall-free stretches
  initial begin
    int unsigned stall;
    int unsigned run_free;
    run_free = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (run_free > 0) begin
        run_free--;
        stall = 0;
      end else if ($urandom_range(0, 15) == 0) begin
        run_free = $urandom_range(10, 40);
        stall = 0;
      end else begin
        stall = $urandom_range(0, 11);
      end
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
    end
  end

  // compare every result transaction with the oldest booked pulse
  always @(posedge clk_i) begin
    jss_pkg::jss_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (pulse_q.size() == 0) begin
        flag_mismatch("unexpected result", 32'(m_axis_tdata_o), 0);
      end else begin
        want = pulse_q.pop_front();
        if (m_axis_tdata_o[0] !== want.tms_level)
          flag_mismatch("tms_level", 32'(m_axis_tdata_o[0]), 32'(want.tms_level));
        if (m_axis_tdata_o[1] !== want.tdi_level)
          flag_mismatch("tdi_level", 32'(m_axis_tdata_o[1]), 32'(want.tdi_level));
        if (m_axis_tlast_o !== want.last)
          flag_mismatch("last", 32'(m_axis_tlast_o), 32'(want.last));
        if (m_axis_tdata_o[17:2] !== want.tdo_word)
          flag_mismatch("tdo_word", 32'(m_axis_tdata_o[17:2]), 32'(want.tdo_word));
      end
    end
  end

  // watchdog on cycles where neither side moves a transaction
  always @(posedge clk_i) begin
    int unsigned quiet;
    if (!rst_ni || (s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("jtag_scan_sequencer regression: fail");
        $finish;
      end
    end
  end

endmodule
